FILE: rtl/dcrp_pkg.sv
// Shared types and constants for the deadband change report packer.
// Used by the front end, the report queue, the serializer and the top level.
package dcrp_pkg;

	localparam int NUM_ADC     = 5;
	localparam int SAMPLE_W    = 10;
	localparam int PORT_W      = 8;
	localparam int WORD_W      = 16;
	localparam int TRIG_W      = 9;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 80;
	localparam int QUEUE_DEPTH = 2;
	localparam int WIDX_W      = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ADC_EN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_P1_MASK   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P2_MASK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P3_MASK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 3'd6;

	localparam logic [WIDX_W-1:0] W_PREAMBLE  = 4'd0;
	localparam logic [WIDX_W-1:0] W_SAMPLE0   = 4'd1;
	localparam logic [WIDX_W-1:0] W_SAMPLE1   = 4'd2;
	localparam logic [WIDX_W-1:0] W_SAMPLE2   = 4'd3;
	localparam logic [WIDX_W-1:0] W_SAMPLE3   = 4'd4;
	localparam logic [WIDX_W-1:0] W_SAMPLE4   = 4'd5;
	localparam logic [WIDX_W-1:0] W_PORT      = 4'd6;
	localparam logic [WIDX_W-1:0] W_TRIGGER   = 4'd7;
	localparam logic [WIDX_W-1:0] W_PORT3     = 4'd8;
	localparam logic [WIDX_W-1:0] W_CHECKSUM  = 4'd9;

	localparam int TRIG_P1   = 5;
	localparam int TRIG_P2   = 6;
	localparam int TRIG_P3   = 7;
	localparam int TRIG_BOOT = 8;

	typedef struct packed {
		logic [NUM_ADC-1:0]  adc_en;
		logic [PORT_W-1:0]   p1_mask;
		logic [PORT_W-1:0]   p2_mask;
		logic [PORT_W-1:0]   p3_mask;
		logic [SAMPLE_W-1:0] deadband;
		logic [SAMPLE_W:0]   ceiling;
	} front_cfg_t;

	typedef struct packed {
		logic [NUM_ADC-1:0][SAMPLE_W-1:0] sample;
		logic [WORD_W-1:0]                port_word;
		logic [TRIG_W-1:0]                trig;
		logic [PORT_W-1:0]                port3;
	} report_rec_t;

endpackage

FILE: rtl/dcrp_front.sv
// Front end: takes scans, detects channel and port changes, keeps the scan history
// and hands a report record to the queue. Depends on dcrp_pkg.
module dcrp_front #(
	parameter int CHANNELS = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dcrp_pkg::front_cfg_t                cfg,
	input  logic                                in_accept,
	input  logic [dcrp_pkg::IN_DATA_W-1:0]      in_data,
	output logic                                push,
	output dcrp_pkg::report_rec_t               rec
);
	import dcrp_pkg::*;

	logic [NUM_ADC-1:0][SAMPLE_W-1:0] accepted_q;
	logic [PORT_W-1:0]                last_p1_q;
	logic [PORT_W-1:0]                last_p2_q;
	logic [PORT_W-1:0]                last_p3_q;
	logic                             boot_q;
	logic [WORD_W-1:0]                packed_port_q;
	logic [PORT_W-1:0]                packed_p3_q;

	logic [NUM_ADC-1:0][SAMPLE_W-1:0] samp;
	logic [NUM_ADC-1:0][SAMPLE_W-1:0] diff;
	logic [NUM_ADC-1:0]               chg;
	logic [PORT_W-1:0]                p1;
	logic [PORT_W-1:0]                p2;
	logic [PORT_W-1:0]                p3;
	logic                             req;
	logic [TRIG_W-1:0]                trig;
	logic                             any_trig;

	always_comb begin
		for (int k = 0; k < NUM_ADC; k++) begin
			samp[k] = in_data[k*SAMPLE_W +: SAMPLE_W];
			diff[k] = (samp[k] >= accepted_q[k]) ? samp[k] - accepted_q[k]
				: accepted_q[k] - samp[k];
			chg[k]  = cfg.adc_en[k] && (k < CHANNELS)
				&& ({1'b0, samp[k]} < cfg.ceiling) && (diff[k] > cfg.deadband);
		end
		p1  = in_data[NUM_ADC*SAMPLE_W +: PORT_W] & cfg.p1_mask;
		p2  = in_data[NUM_ADC*SAMPLE_W+PORT_W +: PORT_W] & cfg.p2_mask;
		p3  = in_data[NUM_ADC*SAMPLE_W+2*PORT_W +: PORT_W] & cfg.p3_mask;
		req = in_data[NUM_ADC*SAMPLE_W+3*PORT_W];
		trig = '0;
		trig[NUM_ADC-1:0] = chg;
		trig[TRIG_P1]     = (p1 != last_p1_q);
		trig[TRIG_P2]     = (p2 != last_p2_q);
		trig[TRIG_P3]     = (p3 != last_p3_q);
		trig[TRIG_BOOT]   = boot_q;
		any_trig = |trig;

		rec.sample    = samp;
		rec.trig      = trig;
		rec.port_word = any_trig ? {p2, p1} : packed_port_q;
		rec.port3     = any_trig ? p3 : packed_p3_q;
		push = in_accept && (any_trig || req);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q    <= '0;
			last_p1_q     <= '0;
			last_p2_q     <= '0;
			last_p3_q     <= '0;
			boot_q        <= 1'b1;
			packed_port_q <= '0;
			packed_p3_q   <= '0;
		end else if (in_accept) begin
			for (int k = 0; k < NUM_ADC; k++) begin
				if (chg[k]) begin
					accepted_q[k] <= samp[k];
				end
			end
			last_p1_q <= p1;
			last_p2_q <= p2;
			last_p3_q <= p3;
			boot_q    <= 1'b0;
			if (any_trig) begin
				packed_port_q <= {p2, p1};
				packed_p3_q   <= p3;
			end
		end
	end

endmodule

FILE: rtl/dcrp_queue.sv
// Short queue of report records between the front end and the serializer.
// Depends on dcrp_pkg.
module dcrp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dcrp_pkg::report_rec_t push_rec,
	input  logic                  pop,
	output logic                  full,
	output logic                  not_empty,
	output dcrp_pkg::report_rec_t head
);
	import dcrp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	report_rec_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/dcrp_serializer.sv
// Back end: walks the head record word by word into the output register and
// builds the checksum on the way. Depends on dcrp_pkg.
module dcrp_serializer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dcrp_pkg::WORD_W-1:0]   preamble,
	input  logic                          rec_valid,
	input  dcrp_pkg::report_rec_t         rec,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dcrp_pkg::WORD_W-1:0]   m_tdata,
	output logic                          m_tlast
);
	import dcrp_pkg::*;

	logic [WIDX_W-1:0] idx_q;
	logic [WORD_W-1:0] sum_q;
	logic              valid_q;
	logic [WORD_W-1:0] data_q;
	logic              last_q;
	logic [WORD_W-1:0] word;
	logic              load;

	always_comb begin
		unique case (idx_q)
			W_PREAMBLE: word = preamble;
			W_SAMPLE0:  word = WORD_W'(rec.sample[0]);
			W_SAMPLE1:  word = WORD_W'(rec.sample[1]);
			W_SAMPLE2:  word = WORD_W'(rec.sample[2]);
			W_SAMPLE3:  word = WORD_W'(rec.sample[3]);
			W_SAMPLE4:  word = WORD_W'(rec.sample[4]);
			W_PORT:     word = rec.port_word;
			W_TRIGGER:  word = WORD_W'(rec.trig);
			W_PORT3:    word = WORD_W'(rec.port3);
			W_CHECKSUM: word = sum_q;
			default:    word = '0;
		endcase
	end

	assign load     = rec_valid && (!valid_q || m_tready);
	assign pop      = load && (idx_q == W_CHECKSUM);
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= W_PREAMBLE;
			sum_q   <= '0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			last_q  <= (idx_q == W_CHECKSUM);
			idx_q   <= (idx_q == W_CHECKSUM) ? W_PREAMBLE : idx_q + 1'b1;
			sum_q   <= (idx_q == W_PREAMBLE) ? '0 : sum_q + word;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= word;
		end
	end

endmodule

FILE: rtl/deadband_change_report_packer_top.sv
// Top level of the deadband change report packer: configuration registers,
// front end, report queue and serializer. Depends on dcrp_pkg and the dcrp_* modules.
//
//  channel  direction  payload
//  s_*      in         one scan: five samples, three port bytes, master request
//  m_*      out        one 16-bit report word, tlast on the checksum
//  cfg_*    in         register write, index 0..6
//
// A scan is taken while s_tready is high; a scan that raises no report is not queued.
// A report is ten words from the serializer, one a cycle while m_tready is high.
// The queue holds two reports, so scans flow while a report drains until it fills.
// s_tready falls only when queue is full; reset clears history, queue, sets boot flag.
module deadband_change_report_packer_top #(
	parameter int CHANNELS = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// adc_ch0..adc_ch4 (10 each), port1_pins, port2_pins, port3_pins, master_request
	input  logic [dcrp_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// report_word
	output logic [dcrp_pkg::WORD_W-1:0]      m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [dcrp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dcrp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dcrp_pkg::*;

	front_cfg_t        cfg_q;
	logic [WORD_W-1:0] preamble_q;
	logic              in_accept;
	logic              push;
	report_rec_t       push_rec;
	logic              pop;
	logic              full;
	logic              not_empty;
	report_rec_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_en   <= 5'd4;
			cfg_q.p1_mask  <= 8'd24;
			cfg_q.p2_mask  <= 8'd248;
			cfg_q.p3_mask  <= 8'd248;
			cfg_q.deadband <= 10'd15;
			cfg_q.ceiling  <= 11'd850;
			preamble_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ADC_EN:   cfg_q.adc_en   <= cfg_data[NUM_ADC-1:0];
				REG_P1_MASK:  cfg_q.p1_mask  <= cfg_data[PORT_W-1:0];
				REG_P2_MASK:  cfg_q.p2_mask  <= cfg_data[PORT_W-1:0];
				REG_P3_MASK:  cfg_q.p3_mask  <= cfg_data[PORT_W-1:0];
				REG_DEADBAND: cfg_q.deadband <= cfg_data[SAMPLE_W-1:0];
				REG_CEILING:  cfg_q.ceiling  <= cfg_data[SAMPLE_W:0];
				REG_PREAMBLE: preamble_q     <= cfg_data[WORD_W-1:0];
				default:      ;
			endcase
		end
	end

	assign s_tready  = !full;
	assign in_accept = s_tvalid && s_tready;

	dcrp_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_accept (in_accept),
		.in_data   (s_tdata),
		.push      (push),
		.rec       (push_rec)
	);

	dcrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	dcrp_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.preamble  (preamble_q),
		.rec_valid (not_empty),
		.rec       (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: rtl/dcrp_checker.sv
// Port-level checks for the report packer: framing, checksum and word contents.
// Depends on dcrp_pkg; bound to deadband_change_report_packer_top.
module dcrp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [dcrp_pkg::WORD_W-1:0]      m_tdata,
	input logic                             m_tlast
);
	import dcrp_pkg::*;

	logic [WIDX_W-1:0] cnt_q;
	logic [WORD_W-1:0] sum_q;
	logic              out_acc;

	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= W_PREAMBLE;
			sum_q <= '0;
		end else if (out_acc) begin
			cnt_q <= m_tlast ? W_PREAMBLE : cnt_q + 1'b1;
			sum_q <= (cnt_q == W_PREAMBLE) ? '0 : sum_q + m_tdata;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (cnt_q == W_CHECKSUM)))
		else $error("tlast not on the tenth word of a report");

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (cnt_q == W_CHECKSUM) |-> (m_tdata == sum_q))
		else $error("checksum word does not match the report");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (cnt_q == W_TRIGGER || cnt_q == W_PORT3) |-> (m_tdata[15:9] == '0))
		else $error("trigger or port 3 word has high bits set");

endmodule

bind deadband_change_report_packer_top dcrp_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
